// ----- hw/rtl/dda_line_pixel_generator_macros.svh -----
// assertion macros for the dda line pixel generator
// no dependencies; included by the top level
`ifndef DDA_LINE_PIXEL_GENERATOR_MACROS_SVH
`define DDA_LINE_PIXEL_GENERATOR_MACROS_SVH

// same-cycle implication
`define DLPG_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("dlpg assertion failed");

// next-cycle implication
`define DLPG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("dlpg assertion failed");

`endif

// ----- hw/rtl/dlpg_pkg.sv -----
// shared types and constants for the dda line pixel generator
// no dependencies
`default_nettype none

package dlpg_pkg;

	localparam int unsigned CoordW       = 12;
	localparam int unsigned PixW         = 13;
	localparam int unsigned DefMaxPixels = 64;
	localparam int unsigned InDataW      = 48;
	localparam int unsigned OutDataW     = 32;
	localparam int unsigned CfgIdxW      = 8;

	localparam logic [CfgIdxW-1:0] CFG_OFFSET_X = 8'd0;
	localparam logic [CfgIdxW-1:0] CFG_OFFSET_Y = 8'd1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIFF,
		ST_CHECK,
		ST_RUN,
		ST_FLAG
	} state_t;

	typedef struct packed {
		logic [CoordW-1:0] adx;
		logic [CoordW-1:0] ady;
		logic              neg_x;
		logic              neg_y;
	} diff_t;

endpackage

`default_nettype wire

// ----- hw/rtl/dlpg_step.sv -----
// dda accumulator: adds the minor length to the remainder and wraps at the major length
// no dependencies
`default_nettype none

module dlpg_step #(
	parameter int unsigned W = 7
) (
	input  wire logic [W-1:0] rem,
	input  wire logic [W-1:0] amin,
	input  wire logic [W-1:0] len,
	output logic      [W-1:0] rem_next,
	output logic              carry
);

	logic [W:0] sum;
	logic [W:0] wrapped;

	always_comb begin
		sum      = {1'b0, rem} + {1'b0, amin};
		wrapped  = sum - {1'b0, len};
		carry    = (sum >= {1'b0, len});
		rem_next = carry ? wrapped[W-1:0] : sum[W-1:0];
	end

endmodule

`default_nettype wire

// ----- hw/rtl/dda_line_pixel_generator.sv -----
// Takes one line segment per transfer and emits one pixel per output transfer along the
// major axis, each shifted by the offset registers; depends on dlpg_pkg, dlpg_step and the macros.
// A line is taken in from ST_IDLE; the block then forms the differences (ST_DIFF), picks
// the axis and checks the length (ST_CHECK), then emits one pixel per cycle while the output
// side is free (ST_RUN), stepping the single accumulator once per pixel; its carry steps
// the minor axis. A zero-length line gives no output; a line longer than MAX_PIXELS gives
// one transfer with tuser set. Input is not accepted while a line is being drawn.
`default_nettype none

`include "dda_line_pixel_generator_macros.svh"

module dda_line_pixel_generator #(
	parameter int unsigned MAX_PIXELS = dlpg_pkg::DefMaxPixels
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_axis_tvalid,
	output logic                               s_axis_tready,
	// start_x, start_y, end_x, end_y
	input  wire logic [dlpg_pkg::InDataW-1:0]  s_axis_tdata,
	output logic                               m_axis_tvalid,
	input  wire logic                          m_axis_tready,
	// pixel_x, pixel_y, zero fill
	output logic      [dlpg_pkg::OutDataW-1:0] m_axis_tdata,
	output logic                               m_axis_tlast,
	// too_long
	output logic                               m_axis_tuser,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [dlpg_pkg::CfgIdxW-1:0]  cfg_index,
	input  wire logic [dlpg_pkg::CoordW-1:0]   cfg_data
);

	import dlpg_pkg::*;

	localparam int unsigned IW = $clog2(MAX_PIXELS + 1);

	state_t state_q, state_d;

	logic [CoordW-1:0] offset_x_q, offset_y_q;
	logic [CoordW-1:0] sx_q, sy_q, ex_q, ey_q;
	diff_t             diff_q;
	logic [CoordW-1:0] len_q, amin_q;
	logic              x_major_q, neg_maj_q, neg_min_q;
	logic [CoordW-1:0] cx_q, cy_q;
	logic [IW-1:0]     i_q, rem_q;

	logic              out_valid_q;
	logic [PixW-1:0]   out_x_q, out_y_q;
	logic              out_last_q, out_flag_q;

	logic              in_xfer, out_free;
	logic [CoordW:0]   dx, dy;
	diff_t             diff_d;
	logic              x_major_d, len_zero, len_over;
	logic [IW-1:0]     len_run, amin_run, rem_next, i_next;
	logic              carry, step_x, step_y, dir_x, dir_y, last_pix;
	logic              load_pix, load_flag;

	dlpg_step #(.W(IW)) u_step (
		.rem      (rem_q),
		.amin     (amin_run),
		.len      (len_run),
		.rem_next (rem_next),
		.carry    (carry)
	);

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_xfer       = s_axis_tvalid && s_axis_tready;
	assign out_free      = !out_valid_q || m_axis_tready;

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(OutDataW - 2 * PixW){1'b0}}, out_y_q, out_x_q};
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tuser  = out_flag_q;

	always_comb begin
		dx           = {1'b0, ex_q} - {1'b0, sx_q};
		dy           = {1'b0, ey_q} - {1'b0, sy_q};
		diff_d.neg_x = dx[CoordW];
		diff_d.neg_y = dy[CoordW];
		diff_d.adx   = dx[CoordW] ? CoordW'(-dx) : dx[CoordW-1:0];
		diff_d.ady   = dy[CoordW] ? CoordW'(-dy) : dy[CoordW-1:0];
		x_major_d    = diff_q.adx > diff_q.ady;
		len_zero     = (diff_q.adx == '0) && (diff_q.ady == '0);
		len_over     = (diff_q.adx > CoordW'(MAX_PIXELS)) ||
			(diff_q.ady > CoordW'(MAX_PIXELS));
		len_run      = len_q[IW-1:0];
		amin_run     = amin_q[IW-1:0];
		i_next       = i_q + IW'(1);
		last_pix     = (i_next == len_run);
		step_x       = x_major_q || carry;
		step_y       = !x_major_q || carry;
		dir_x        = x_major_q ? neg_maj_q : neg_min_q;
		dir_y        = x_major_q ? neg_min_q : neg_maj_q;
	end

	always_comb begin
		state_d   = state_q;
		load_pix  = 1'b0;
		load_flag = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_xfer) state_d = ST_DIFF;
			end
			ST_DIFF: begin
				state_d = ST_CHECK;
			end
			ST_CHECK: begin
				if (len_zero) state_d = ST_IDLE;
				else if (len_over) state_d = ST_FLAG;
				else state_d = ST_RUN;
			end
			ST_RUN: begin
				if (out_free) begin
					load_pix = 1'b1;
					if (last_pix) state_d = ST_IDLE;
				end
			end
			ST_FLAG: begin
				if (out_free) begin
					load_flag = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			offset_x_q  <= '0;
			offset_y_q  <= '0;
		end else begin
			state_q <= state_d;
			if (load_pix || load_flag) out_valid_q <= 1'b1;
			else if (m_axis_tready) out_valid_q <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_OFFSET_X: offset_x_q <= cfg_data;
					CFG_OFFSET_Y: offset_y_q <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			sx_q <= s_axis_tdata[11:0];
			sy_q <= s_axis_tdata[23:12];
			ex_q <= s_axis_tdata[35:24];
			ey_q <= s_axis_tdata[47:36];
		end
		if (state_q == ST_DIFF) diff_q <= diff_d;
		if (state_q == ST_CHECK) begin
			x_major_q <= x_major_d;
			len_q     <= x_major_d ? diff_q.adx : diff_q.ady;
			amin_q    <= x_major_d ? diff_q.ady : diff_q.adx;
			neg_maj_q <= x_major_d ? diff_q.neg_x : diff_q.neg_y;
			neg_min_q <= x_major_d ? diff_q.neg_y : diff_q.neg_x;
			cx_q      <= sx_q;
			cy_q      <= sy_q;
			i_q       <= '0;
			rem_q     <= '0;
		end
		if (load_pix) begin
			out_x_q    <= {1'b0, cx_q} + {1'b0, offset_x_q};
			out_y_q    <= {1'b0, cy_q} + {1'b0, offset_y_q};
			out_last_q <= last_pix;
			out_flag_q <= 1'b0;
			i_q        <= i_next;
			rem_q      <= rem_next;
			if (step_x) cx_q <= dir_x ? cx_q - CoordW'(1) : cx_q + CoordW'(1);
			if (step_y) cy_q <= dir_y ? cy_q - CoordW'(1) : cy_q + CoordW'(1);
		end
		if (load_flag) begin
			out_x_q    <= '0;
			out_y_q    <= '0;
			out_last_q <= 1'b1;
			out_flag_q <= 1'b1;
		end
	end

	// checks
	`DLPG_ASSERT_IMPL(a_flag_is_last, clk, arst_n, m_axis_tvalid && m_axis_tuser, m_axis_tlast)
	`DLPG_ASSERT_IMPL(a_index_in_range, clk, arst_n, state_q == ST_RUN, i_q < len_run)
	`DLPG_ASSERT_IMPL(a_rem_in_range, clk, arst_n, state_q == ST_RUN, rem_q < len_run)
	`DLPG_ASSERT_NEXT(a_busy_after_take, clk, arst_n, in_xfer, !s_axis_tready)

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
// self-checking bench for dda_line_pixel_generator: line segments in, pixel transfers out
// pixel queue predicted per accepted line and matched in order; needs dlpg_pkg and the rtl
`default_nettype none

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import dlpg_pkg::*;

	localparam int MaxPix     = DefMaxPixels;
	localparam int HoldCycles = 300;
	localparam int Limit      = 1000000;
	localparam int PhaseItems = 102;

	typedef struct packed {
		logic [PixW-1:0] x;
		logic [PixW-1:0] y;
		logic            last;
		logic            too_long;
	} pixel_t;

	class line_scoreboard;
		pixel_t            pixels_due[$];
		logic [CoordW-1:0] off_x;
		logic [CoordW-1:0] off_y;
		int                fails;

		function new();
			off_x = '0;
			off_y = '0;
			fails = 0;
		endfunction

		function void set_reg(logic [CfgIdxW-1:0] idx, logic [CoordW-1:0] val);
			if (idx == CFG_OFFSET_X)
				off_x = val;
			else if (idx == CFG_OFFSET_Y)
				off_y = val;
		endfunction

		function void note_line(logic [InDataW-1:0] d);
			int sx, sy, ex, ey, dx, dy, adx, ady, len, amin, smaj, smin, maj, mnr, i;
			bit x_major;
			pixel_t p;
			sx = d[11:0];
			sy = d[23:12];
			ex = d[35:24];
			ey = d[47:36];
			dx = ex - sx;
			dy = ey - sy;
			adx = dx < 0 ? -dx : dx;
			ady = dy < 0 ? -dy : dy;
			x_major = adx > ady;
			len = x_major ? adx : ady;
			amin = x_major ? ady : adx;
			smaj = ((x_major ? dx : dy) < 0) ? -1 : 1;
			smin = ((x_major ? dy : dx) < 0) ? -1 : 1;
			if (len == 0)
				return;
			if (len > MaxPix) begin
				p = '{x: '0, y: '0, last: 1'b1, too_long: 1'b1};
				pixels_due.push_back(p);
				return;
			end
			for (i = 0; i < len; i++) begin
				maj = smaj * i;
				mnr = smin * ((i * amin) / len);
				p.x = PixW'(sx + int'(off_x) + (x_major ? maj : mnr));
				p.y = PixW'(sy + int'(off_y) + (x_major ? mnr : maj));
				p.last = (i == len - 1);
				p.too_long = 1'b0;
				pixels_due.push_back(p);
			end
		endfunction

		function void check_pixel(pixel_t got);
			pixel_t want;
			if (pixels_due.size() == 0) begin
				fails++;
				$display("%0t: unexpected transfer x=%0d y=%0d last=%0b too_long=%0b",
					$time, got.x, got.y, got.last, got.too_long);
				return;
			end
			want = pixels_due.pop_front();
			if (got.x !== want.x) begin
				fails++;
				$display("%0t: pixel_x expected %0d actual %0d", $time, want.x, got.x);
			end
			if (got.y !== want.y) begin
				fails++;
				$display("%0t: pixel_y expected %0d actual %0d", $time, want.y, got.y);
			end
			if (got.last !== want.last) begin
				fails++;
				$display("%0t: last expected %0b actual %0b", $time, want.last, got.last);
			end
			if (got.too_long !== want.too_long) begin
				fails++;
				$display("%0t: too_long expected %0b actual %0b", $time,
					want.too_long, got.too_long);
			end
		endfunction
	endclass

	logic                clk           = 1'b0;
	logic                arst_n        = 1'b0;
	logic                s_axis_tvalid = 1'b0;
	logic                s_axis_tready;
	// start_x, start_y, end_x, end_y
	logic [InDataW-1:0]  s_axis_tdata  = '0;
	logic                m_axis_tvalid;
	logic                m_axis_tready = 1'b0;
	// pixel_x, pixel_y, zero fill
	logic [OutDataW-1:0] m_axis_tdata;
	logic                m_axis_tlast;
	// too_long
	logic                m_axis_tuser;
	logic                cfg_valid     = 1'b0;
	logic                cfg_ready;
	logic [CfgIdxW-1:0]  cfg_index     = '0;
	logic [CoordW-1:0]   cfg_data      = '0;

	line_scoreboard sb = new();

	int src_idle_pct  = 0;
	int snk_stall_pct = 0;
	int hold_req      = 0;
	int hold_ack      = 0;
	int hold_left     = 0;
	int cycles        = 0;

	dda_line_pixel_generator #(.MAX_PIXELS(MaxPix)) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast),
		.m_axis_tuser (m_axis_tuser),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// receiver: random stalls, plus a long hold-off on request
	always @(posedge clk) begin
		if (hold_req != hold_ack) begin
			hold_ack <= hold_req;
			hold_left <= HoldCycles;
			m_axis_tready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(0, 99) >= snk_stall_pct);
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= Limit) begin
			$display("*** FAILED ***");
			$finish;
		end else if (arst_n && m_axis_tvalid && m_axis_tready) begin
			sb.check_pixel('{x: m_axis_tdata[12:0], y: m_axis_tdata[25:13],
				last: m_axis_tlast, too_long: m_axis_tuser});
		end
	end

	function automatic logic [InDataW-1:0] mk_line(int sx, int sy, int ex, int ey);
		return {ey[11:0], ex[11:0], sy[11:0], sx[11:0]};
	endfunction

	function automatic logic [InDataW-1:0] rand_line();
		int sx, sy, ex, ey, len, mn, dx, dy, pick;
		pick = $urandom_range(0, 99);
		sx = $urandom_range(0, 4095);
		sy = $urandom_range(0, 4095);
		if (pick < 5) begin
			ex = sx;
			ey = sy;
		end else if (pick < 15) begin
			ex = $urandom_range(0, 4095);
			ey = $urandom_range(0, 4095);
		end else begin
			if (pick < 21)
				len = $urandom_range(65, 80);
			else if ($urandom_range(0, 9) == 0)
				len = $urandom_range(33, 64);
			else
				len = $urandom_range(1, 32);
			mn = $urandom_range(0, len);
			if ($urandom_range(0, 1)) begin
				dx = len;
				dy = mn;
			end else begin
				dx = mn;
				dy = len;
			end
			if ($urandom_range(0, 1))
				dx = -dx;
			if ($urandom_range(0, 1))
				dy = -dy;
			ex = (sx + dx < 0 || sx + dx > 4095) ? sx - dx : sx + dx;
			ey = (sy + dy < 0 || sy + dy > 4095) ? sy - dy : sy + dy;
		end
		return mk_line(sx, sy, ex, ey);
	endfunction

	task automatic send_line(logic [InDataW-1:0] d);
		if ($urandom_range(0, 99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(0, 99) < src_idle_pct);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= d;
		do
			@(posedge clk);
		while (!s_axis_tready);
		sb.note_line(d);
	endtask

	task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CoordW-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		sb.set_reg(idx, val);
	endtask

	// wait for every pixel, then let a zero-length line finish inside the block
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (sb.pixels_due.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic run_phase(int src_pct, int snk_pct, logic [CoordW-1:0] ox,
			logic [CoordW-1:0] oy, bit pressure);
		int n;
		drain();
		write_reg(CFG_OFFSET_X, ox);
		write_reg(CFG_OFFSET_Y, oy);
		write_reg(CfgIdxW'($urandom_range(2, 255)), CoordW'($urandom_range(0, 4095)));
		cfg_valid <= 1'b0;
		src_idle_pct = src_pct;
		snk_stall_pct = snk_pct;
		if (pressure)
			hold_req <= hold_req + 1;
		for (n = 0; n < PhaseItems; n++)
			send_line(rand_line());
	endtask

	initial begin
		logic [InDataW-1:0] directed[$];
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		write_reg(CFG_OFFSET_X, '0);
		write_reg(CFG_OFFSET_Y, '0);
		cfg_valid <= 1'b0;

		directed = '{
			mk_line(0, 0, 0, 0),
			mk_line(4095, 4095, 4095, 4095),
			mk_line(0, 0, 64, 0),
			mk_line(0, 0, 65, 0),
			mk_line(0, 0, 4095, 4095),
			mk_line(4095, 0, 0, 4095),
			mk_line(4095, 4095, 4031, 4090),
			mk_line(10, 10, 13, 20),
			mk_line(100, 200, 90, 150),
			mk_line(5, 5, 9, 9),
			mk_line(20, 20, 16, 24),
			mk_line(7, 7, 8, 7),
			mk_line(7, 7, 7, 6),
			mk_line(50, 50, 40, 53),
			mk_line(50, 50, 58, 43),
			mk_line(0, 0, 0, 65),
			mk_line(0, 4095, 3, 4031),
			mk_line(2730, 1365, 2700, 1400),
			mk_line(1365, 2730, 1400, 2700),
			mk_line(4095, 0, 4095, 64),
			mk_line(0, 4095, 64, 4095),
			mk_line(4032, 4032, 4095, 4095)
		};
		foreach (directed[k])
			send_line(directed[k]);

		run_phase(0, 0, 12'hFFF, 12'hFFF, 1'b1);
		run_phase(72, 0, CoordW'($urandom_range(0, 4095)), CoordW'($urandom_range(0, 4095)),
			1'b0);
		run_phase(0, 72, 12'h000, 12'hFFF, 1'b0);
		run_phase(13, 13, CoordW'($urandom_range(0, 4095)), CoordW'($urandom_range(0, 4095)),
			1'b0);
		drain();

		if (sb.fails == 0 && sb.pixels_due.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

`default_nettype wire
